// File: hdl/fspa_pkg.sv
// shared types, codes and constants of the fixed-size pool allocator
`default_nettype none
package fspa_pkg;

  localparam int ADDR_W      = 16;
  localparam int ALIGN_BYTES = 8;
  localparam int ALIGN_SHIFT = 3;
  localparam int LINK_AW     = ADDR_W - ALIGN_SHIFT;
  localparam int LINK_DEPTH  = 1 << LINK_AW;
  localparam int NUM_CLASSES = 4;
  localparam int CLS_W       = 2;
  localparam int EXTRA_W     = 8;
  localparam int SIZE_W      = 13;
  localparam int ITEM_W      = 14;
  localparam int FREE_W      = 14;
  localparam int BLOCK_W     = 10;
  localparam int TOP_W       = ADDR_W + 1;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int ITEM_MAX    =
    (((1 << EXTRA_W) - 1 + (1 << SIZE_W) - 1 + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;

  localparam int ITEMS_PER_BLOCK_DEF = 20;
  localparam int HEAP_BYTES_DEF      = 65536;
  localparam int HEADER_BYTES_DEF    = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EXTRA  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS0 = 3'd1;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_QUERY = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_MEM  = 2'd1,
    ST_NOT_SET = 2'd2,
    ST_TOO_BIG = 2'd3
  } status_e;

  typedef struct packed {
    logic              set;
    logic [ITEM_W-1:0] item;
  } cls_cfg_t;

endpackage
`default_nettype wire

// File: hdl/fixed_size_pool_allocator.sv
// fixed-size pool allocator: per-class lifo free lists refilled from a bump heap
//
//   channel  | direction | handshake                    | contents
//   s_axis   | in        | s_axis_tvalid / s_axis_tready | request item
//   m_axis   | out       | m_axis_tvalid / m_axis_tready | result item
//   cfg      | in        | cfg_we_i                      | register writes
//
// one request at a time; free, query, class-not-set and too-large cases go
// from decode straight to the result, an out-of-memory allocate adds one fit
// check, an allocate from a non-empty list one link ram read.
// a refill adds one fit check, then one push per cycle through the address
// adder and the link ram write port, which frees share.
// tready returns the cycle after the result loads; a result still unaccepted
// in the output register holds the next one back until m_axis_tready.
// reset empties every list and the heap; the link ram needs no clearing.
`default_nettype none
module fixed_size_pool_allocator #(
  parameter int ITEMS_PER_BLOCK = fspa_pkg::ITEMS_PER_BLOCK_DEF,
  parameter int HEAP_BYTES      = fspa_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES    = fspa_pkg::HEADER_BYTES_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // class_index[1:0], request_size[14:2], item_address[30:15], zero[31]
  input  wire logic [31:0]                        s_axis_tdata,
  // action[1:0]
  input  wire logic [1:0]                         s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // granted_address[15:0], free_count[29:16], block_count[39:30]
  output logic      [39:0]                        m_axis_tdata,
  // status[1:0]
  output logic      [1:0]                         m_axis_tuser,
  input  wire logic                               cfg_we_i,
  input  wire logic [fspa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [fspa_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import fspa_pkg::*;

  localparam int HDR_SPAN   = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam int HEAP_LIMIT = (HEAP_BYTES > (1 << ADDR_W)) ? (1 << ADDR_W) : HEAP_BYTES;
  localparam int NEED_W     = $clog2(ITEMS_PER_BLOCK * ITEM_MAX + HDR_SPAN + 1);
  localparam int SUM_W      = ((NEED_W > TOP_W) ? NEED_W : TOP_W) + 1;
  localparam int K_W        = (ITEMS_PER_BLOCK > 1) ? $clog2(ITEMS_PER_BLOCK) : 1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_CHECK  = 7'b0000100,
    S_CARVE  = 7'b0001000,
    S_POP_RD = 7'b0010000,
    S_POP_WB = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e                     state_q, state_d;
  cls_cfg_t [NUM_CLASSES-1:0] cls_cfg;

  // latched request
  logic [1:0]                 act_q;
  logic [CLS_W-1:0]           cls_q;
  logic [SIZE_W-1:0]          req_q;
  logic [ADDR_W-1:0]          addr_q;

  status_e                    status_q, status_d;
  logic [ADDR_W-1:0]          granted_q, granted_d;
  logic [NEED_W-1:0]          need_q, need_d;
  logic [TOP_W-1:0]           acc_q, acc_d;
  logic [K_W-1:0]             k_q, k_d;
  logic [TOP_W-1:0]           heap_q, heap_d;

  logic [LINK_AW-1:0]         head_q  [NUM_CLASSES];
  logic [LINK_AW-1:0]         head_d  [NUM_CLASSES];
  logic [NUM_CLASSES-1:0]     empty_q, empty_d;
  logic [FREE_W-1:0]          freec_q [NUM_CLASSES];
  logic [FREE_W-1:0]          freec_d [NUM_CLASSES];
  logic [BLOCK_W-1:0]         blockc_q [NUM_CLASSES];
  logic [BLOCK_W-1:0]         blockc_d [NUM_CLASSES];

  logic                       in_fire;
  logic                       push_en;
  logic [LINK_AW-1:0]         push_idx;
  logic [LINK_AW-1:0]         link_rdata;
  logic [ITEM_W-1:0]          item;
  logic                       cls_set;
  logic [FREE_W-1:0]          free_dec;
  logic                       out_load;

  logic                       out_valid_q, out_valid_d;
  status_e                    out_status_q;
  logic [ADDR_W-1:0]          out_granted_q;
  logic [FREE_W-1:0]          out_free_q;
  logic [BLOCK_W-1:0]         out_block_q;

  fspa_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cls_cfg_o   (cls_cfg)
  );

  fspa_ram #(
    .WIDTH (LINK_AW),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (push_en),
    .waddr_i (push_idx),
    .wdata_i (head_q[cls_q]),
    .raddr_i (head_q[cls_q]),
    .rdata_o (link_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign item          = cls_cfg[cls_q].item;
  assign cls_set       = cls_cfg[cls_q].set;
  assign free_dec      = freec_q[cls_q] - FREE_W'(freec_q[cls_q] != '0);

  always_comb begin
    state_d   = state_q;
    status_d  = status_q;
    granted_d = granted_q;
    need_d    = need_q;
    acc_d     = acc_q;
    k_d       = k_q;
    heap_d    = heap_q;
    head_d    = head_q;
    empty_d   = empty_q;
    freec_d   = freec_q;
    blockc_d  = blockc_q;
    push_en   = 1'b0;
    push_idx  = addr_q[ADDR_W-1:ALIGN_SHIFT];
    out_load  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        status_d  = ST_OK;
        granted_d = '0;
        state_d   = S_DONE;
        if (!cls_set) begin
          status_d = ST_NOT_SET;
        end else begin
          unique case (act_q)
            ACT_ALLOC: begin
              if (ITEM_W'(req_q) > item) begin
                status_d = ST_TOO_BIG;
              end else if (empty_q[cls_q]) begin
                need_d  = NEED_W'(ITEMS_PER_BLOCK) * NEED_W'(item) + NEED_W'(HDR_SPAN);
                acc_d   = heap_q + TOP_W'(HDR_SPAN);
                state_d = S_CHECK;
              end else begin
                state_d = S_POP_RD;
              end
            end
            ACT_FREE: begin
              push_en = 1'b1;
            end
            default: begin
              // query, and action three behaves the same
            end
          endcase
        end
      end
      S_CHECK: begin
        if (SUM_W'(heap_q) + SUM_W'(need_q) > SUM_W'(HEAP_LIMIT)) begin
          status_d = ST_NO_MEM;
          state_d  = S_DONE;
        end else begin
          k_d     = '0;
          state_d = S_CARVE;
        end
      end
      S_CARVE: begin
        // one item per cycle, ascending, so the highest ends up on top
        push_en  = 1'b1;
        push_idx = acc_q[ADDR_W-1:ALIGN_SHIFT];
        acc_d    = acc_q + TOP_W'(item);
        k_d      = k_q + K_W'(1);
        if (k_q == K_W'(ITEMS_PER_BLOCK - 1)) begin
          // address past the last item is the new heap top
          heap_d = acc_d;
          if (blockc_q[cls_q] != '1) begin
            blockc_d[cls_q] = blockc_q[cls_q] + BLOCK_W'(1);
          end
          state_d = S_POP_RD;
        end
      end
      S_POP_RD: begin
        granted_d = {head_q[cls_q], {ALIGN_SHIFT{1'b0}}};
        state_d   = S_POP_WB;
      end
      S_POP_WB: begin
        head_d[cls_q]  = link_rdata;
        freec_d[cls_q] = free_dec;
        if (free_dec == '0) begin
          empty_d[cls_q] = 1'b1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (push_en) begin
      head_d[cls_q]  = push_idx;
      empty_d[cls_q] = 1'b0;
      if (freec_q[cls_q] != '1) begin
        freec_d[cls_q] = freec_q[cls_q] + FREE_W'(1);
      end
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      heap_q      <= '0;
      empty_q     <= '1;
      out_valid_q <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_q[c]   <= '0;
        freec_q[c]  <= '0;
        blockc_q[c] <= '0;
      end
    end else begin
      state_q     <= state_d;
      heap_q      <= heap_d;
      empty_q     <= empty_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      freec_q     <= freec_d;
      blockc_q    <= blockc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q  <= s_axis_tuser;
      cls_q  <= s_axis_tdata[CLS_W-1:0];
      req_q  <= s_axis_tdata[CLS_W+SIZE_W-1:CLS_W];
      addr_q <= s_axis_tdata[CLS_W+SIZE_W+ADDR_W-1:CLS_W+SIZE_W];
    end
    status_q  <= status_d;
    granted_q <= granted_d;
    need_q    <= need_d;
    acc_q     <= acc_d;
    k_q       <= k_d;
    if (out_load) begin
      out_status_q  <= status_q;
      out_granted_q <= granted_q;
      out_free_q    <= cls_set ? freec_q[cls_q] : '0;
      out_block_q   <= cls_set ? blockc_q[cls_q] : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {out_block_q, out_free_q, out_granted_q};

endmodule
`default_nettype wire

// File: hdl/fspa_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none
module fspa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: hdl/fspa_cfg.sv
// configuration registers and latched item size of each class
`default_nettype none
module fspa_cfg (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [fspa_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [fspa_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output fspa_pkg::cls_cfg_t [fspa_pkg::NUM_CLASSES-1:0] cls_cfg_o
);
  import fspa_pkg::*;

  logic [EXTRA_W-1:0]                 extra_q, extra_d;
  cls_cfg_t [NUM_CLASSES-1:0]         cls_q, cls_d;
  logic [CLS_W-1:0]                   sel;
  logic                               sel_ok;
  logic [SIZE_W-1:0]                  size_val;
  logic [ITEM_W-1:0]                  sum;

  always_comb begin
    extra_d  = extra_q;
    cls_d    = cls_q;
    sel      = CLS_W'(cfg_index_i - REG_CLASS0);
    sel_ok   = (int'(cfg_index_i) >= int'(REG_CLASS0)) &&
               (int'(cfg_index_i) < int'(REG_CLASS0) + NUM_CLASSES);
    size_val = cfg_data_i[SIZE_W-1:0];
    // round extra plus size up to the alignment
    sum      = ITEM_W'(extra_q) + ITEM_W'(size_val) + ITEM_W'(ALIGN_BYTES - 1);
    if (cfg_we_i) begin
      if (cfg_index_i == REG_EXTRA) begin
        extra_d = cfg_data_i[EXTRA_W-1:0];
      end else if (sel_ok && !cls_q[sel].set && size_val != '0) begin
        // first nonzero write latches the size, later ones are ignored
        cls_d[sel].set  = 1'b1;
        cls_d[sel].item = sum & ~ITEM_W'(ALIGN_BYTES - 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extra_q <= '0;
      cls_q   <= '0;
    end else begin
      extra_q <= extra_d;
      cls_q   <= cls_d;
    end
  end

  assign cls_cfg_o = cls_q;

endmodule
`default_nettype wire

// File: bench/tb_fixed_size_pool_allocator.sv
// self-checking testbench of the fixed-size pool allocator
`timescale 1ns / 1ps
module tb_fixed_size_pool_allocator;
  import fspa_pkg::*;

  localparam int HEAP_LIMIT   = (HEAP_BYTES_DEF > 65536) ? 65536 : HEAP_BYTES_DEF;
  localparam int HDR_SPAN     =
    ((HEADER_BYTES_DEF + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam int FREE_MAX     = (1 << FREE_W) - 1;
  localparam int BLOCK_MAX    = (1 << BLOCK_W) - 1;
  localparam int REQ_MAX      = 4351;
  localparam int SETTLE_CYCLES = 32;
  localparam logic [1:0] ACT_ALIAS_QUERY = 2'd3;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] granted;
    logic [FREE_W-1:0] free_cnt;
    logic [BLOCK_W-1:0] block_cnt;
  } pool_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // allocator state as the bench sees it
  int next_link [LINK_DEPTH];
  int head_idx [NUM_CLASSES];
  bit list_is_empty [NUM_CLASSES];
  int free_items [NUM_CLASSES];
  int blocks_carved [NUM_CLASSES];
  int heap_top_bytes;
  int extra_reg;
  int class_size_reg [NUM_CLASSES];
  int item_bytes [NUM_CLASSES];

  pool_result_t pending_outcomes[$];
  int live_items[$];  // class in bits 17:16, granted address below

  int error_count = 0;
  int results_checked = 0;
  int requests_sent = 0;
  int status_seen [4];
  bit tx_idle_on = 1'b1;
  int tx_burst_left = 0;
  bit rx_stall_on = 1'b1;
  int rx_hold = 0;

  fixed_size_pool_allocator #(
    .ITEMS_PER_BLOCK(ITEMS_PER_BLOCK_DEF),
    .HEAP_BYTES     (HEAP_BYTES_DEF),
    .HEADER_BYTES   (HEADER_BYTES_DEF)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic void push_free(input int c, input int idx);
    idx = idx % LINK_DEPTH;
    next_link[idx] = head_idx[c];
    head_idx[c] = idx;
    list_is_empty[c] = 1'b0;
    if (free_items[c] < FREE_MAX) free_items[c]++;
  endfunction

  function automatic int pop_free(input int c);
    int idx;
    idx = head_idx[c] % LINK_DEPTH;
    head_idx[c] = next_link[idx];
    if (free_items[c] > 0) free_items[c]--;
    if (free_items[c] == 0) list_is_empty[c] = 1'b1;
    return idx;
  endfunction

  function automatic void apply_register_write(input logic [CFG_IDX_W-1:0] idx,
                                               input int val);
    int c;
    if (idx == REG_EXTRA) begin
      extra_reg = val & 'hFF;
    end else if (idx >= REG_CLASS0 && int'(idx - REG_CLASS0) < NUM_CLASSES) begin
      c = int'(idx - REG_CLASS0);
      // a class size is latched once; later writes are dropped
      if (class_size_reg[c] == 0) begin
        class_size_reg[c] = val & 'h1FFF;
        if (class_size_reg[c] != 0)
          item_bytes[c] = ((extra_reg + class_size_reg[c] + ALIGN_BYTES - 1) / ALIGN_BYTES)
                          * ALIGN_BYTES;
      end
    end
  endfunction

  // outcome of one request, advancing the allocator state
  function automatic pool_result_t allocator_outcome(input logic [1:0] act, input int c,
                                                     input int req, input int addr);
    pool_result_t r;
    int need;
    int base;
    bit have_item;
    r = '0;
    r.status = ST_OK;
    if (c >= NUM_CLASSES || class_size_reg[c] == 0) begin
      r.status = ST_NOT_SET;
      return r;
    end
    if (act == ACT_ALLOC) begin
      if (req > item_bytes[c]) begin
        r.status = ST_TOO_BIG;
      end else begin
        have_item = 1'b1;
        if (list_is_empty[c]) begin
          need = ITEMS_PER_BLOCK_DEF * item_bytes[c] + HDR_SPAN;
          if (heap_top_bytes + need > HEAP_LIMIT) begin
            have_item = 1'b0;
          end else begin
            base = heap_top_bytes + HDR_SPAN;
            for (int k = 0; k < ITEMS_PER_BLOCK_DEF; k++)
              push_free(c, (base + k * item_bytes[c]) / ALIGN_BYTES);
            heap_top_bytes += need;
            if (blocks_carved[c] < BLOCK_MAX) blocks_carved[c]++;
          end
        end
        if (!have_item) r.status = ST_NO_MEM;
        else r.granted = ADDR_W'(pop_free(c) * ALIGN_BYTES);
      end
    end else if (act == ACT_FREE) begin
      push_free(c, addr / ALIGN_BYTES);
    end
    r.free_cnt = FREE_W'(free_items[c]);
    r.block_cnt = BLOCK_W'(blocks_carved[c]);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic send_request(input logic [1:0] act, input int c, input int req,
                              input int addr, output pool_result_t outcome);
    int gap;
    if (tx_idle_on) begin
      if (tx_burst_left == 0) begin
        gap = $urandom_range(1, 10);
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
        tx_burst_left = $urandom_range(1, 12);
      end
      tx_burst_left--;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = act;
    s_axis_tdata = {1'b0, addr[15:0], req[12:0], c[1:0]};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    outcome = allocator_outcome(act, c, req, addr);
    pending_outcomes.push_back(outcome);
    requests_sent++;
    status_seen[outcome.status]++;
    if (act == ACT_ALLOC && outcome.status == ST_OK)
      live_items.push_back((c << 16) | int'(outcome.granted));
  endtask

  // hold the sender until every result is back and the block has gone quiet
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val[CFG_DATA_W-1:0];
    apply_register_write(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // receiver: random stalls, or always ready
  always @(negedge clk_i) begin
    if (!rx_stall_on) begin
      m_axis_tready = 1'b1;
    end else if (rx_hold > 0) begin
      m_axis_tready = 1'b0;
      rx_hold--;
    end else begin
      m_axis_tready = 1'b1;
      if ($urandom_range(0, 4) == 0) rx_hold = $urandom_range(1, 7);
    end
  end

  always @(posedge clk_i) begin
    pool_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected result item", int'(m_axis_tuser), -1);
      end else begin
        want = pending_outcomes.pop_front();
        results_checked++;
        if (m_axis_tuser !== want.status)
          report_mismatch("status", int'(m_axis_tuser), int'(want.status));
        if (m_axis_tdata[15:0] !== want.granted)
          report_mismatch("granted_address", int'(m_axis_tdata[15:0]), int'(want.granted));
        if (m_axis_tdata[29:16] !== want.free_cnt)
          report_mismatch("free_count", int'(m_axis_tdata[29:16]), int'(want.free_cnt));
        if (m_axis_tdata[39:30] !== want.block_cnt)
          report_mismatch("block_count", int'(m_axis_tdata[39:30]), int'(want.block_cnt));
      end
    end
  end

  task automatic test_unset_classes();
    pool_result_t r;
    send_request(ACT_ALLOC, 0, 8, 0, r);
    send_request(ACT_FREE, 1, 0, 'hFFFF, r);
    send_request(ACT_QUERY, 2, 0, 0, r);
    send_request(ACT_ALIAS_QUERY, 3, REQ_MAX, 'h5555, r);
    drain_results();
  endtask

  task automatic test_class_setup();
    write_register(REG_EXTRA, 0);
    write_register(REG_CLASS0, 1);          // smallest item, 8 bytes
    write_register(REG_CLASS0 + 3'd2, 0);   // zero leaves the class unset
    write_register(REG_EXTRA, 255);
    write_register(REG_CLASS0 + 3'd1, 4096); // too big for any block to fit
    write_register(REG_EXTRA, 5);
    write_register(REG_CLASS0 + 3'd2, 1000);
  endtask

  task automatic test_basic_ops();
    pool_result_t r;
    send_request(ACT_ALLOC, 0, 8, 0, r);     // first refill, top item comes out
    send_request(ACT_QUERY, 0, 0, 0, r);
    send_request(ACT_ALLOC, 0, 0, 0, r);
    send_request(ACT_FREE, 0, 0, int'(r.granted), r);
    send_request(ACT_ALLOC, 0, 9, 0, r);     // one byte over the item size
    send_request(ACT_FREE, 0, 0, 'h0FFF, r); // unaligned, truncated on push
    send_request(ACT_ALLOC, 0, 8, 0, r);
    send_request(ACT_ALIAS_QUERY, 0, 0, 0, r);
    // pause until the pipeline is empty, then continue
    drain_results();
    send_request(ACT_ALLOC, 1, 4352, 0, r);  // block does not fit in the heap
    send_request(ACT_ALLOC, 1, 4353, 0, r);
    send_request(ACT_FREE, 1, 0, 0, r);
    send_request(ACT_ALLOC, 1, REQ_MAX, 0, r);
    send_request(ACT_ALLOC, 2, 1008, 'hFFFF, r);
    send_request(ACT_FREE, 2, 0, 'hFFF8, r);
    send_request(ACT_QUERY, 3, 0, 0, r);
    send_request(ACT_ALLOC, 3, 1, 0, r);
    drain_results();
  endtask

  task automatic test_latched_sizes();
    pool_result_t r;
    write_register(REG_EXTRA, $urandom_range(0, 40));
    write_register(REG_CLASS0, 4000);        // class 0 already latched
    write_register(REG_CLASS0 + 3'd3, $urandom_range(150, 250));
    write_register(REG_CLASS0 + 3'd2, 8);
    send_request(ACT_ALLOC, 0, 8, 0, r);
    send_request(ACT_ALLOC, 0, 9, 0, r);
    send_request(ACT_ALLOC, 3, item_bytes[3], 0, r);
    drain_results();
  endtask

  task automatic test_heap_exhaustion();
    pool_result_t r;
    int tries;
    for (int c = 2; c <= 3; c++) begin
      tries = 0;
      do begin
        send_request(ACT_ALLOC, c, $urandom_range(0, item_bytes[c]),
                     $urandom_range(0, 65535), r);
        tries++;
      end while (r.status != ST_NO_MEM && tries < 100);
    end
    drain_results();
  endtask

  task automatic test_random_traffic(input int count, input int alloc_pct,
                                     input int free_pct);
    pool_result_t r;
    logic [1:0] act;
    int c;
    int roll;
    int req;
    int addr;
    int pick;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      c = $urandom_range(0, NUM_CLASSES - 1);
      if (roll < alloc_pct) act = ACT_ALLOC;
      else if (roll < alloc_pct + free_pct) act = ACT_FREE;
      else if (roll < 96) act = ACT_QUERY;
      else act = ACT_ALIAS_QUERY;
      if ($urandom_range(0, 6) == 0) req = $urandom_range(0, REQ_MAX);
      else req = $urandom_range(0, (item_bytes[c] > REQ_MAX) ? REQ_MAX : item_bytes[c]);
      addr = $urandom_range(0, 65535);
      // most frees hand back a live item; the rest are stray addresses
      if (act == ACT_FREE && live_items.size() != 0 && $urandom_range(0, 9) < 8) begin
        pick = $urandom_range(0, live_items.size() - 1);
        c = live_items[pick] >> 16;
        addr = live_items[pick] & 'hFFFF;
        live_items.delete(pick);
      end
      send_request(act, c, req, addr, r);
    end
    drain_results();
  endtask

  initial begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      head_idx[c] = 0;
      list_is_empty[c] = 1'b1;
      free_items[c] = 0;
      blocks_carved[c] = 0;
      class_size_reg[c] = 0;
      item_bytes[c] = 0;
    end
    for (int s = 0; s < 4; s++) status_seen[s] = 0;
    heap_top_bytes = 0;
    extra_reg = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_unset_classes();
    test_class_setup();
    test_basic_ops();
    test_latched_sizes();
    test_heap_exhaustion();
    test_random_traffic(260, 50, 30);
    write_register(REG_EXTRA, 255);
    tx_idle_on = 1'b0;
    rx_stall_on = 1'b0;
    test_random_traffic(260, 65, 20);
    write_register(REG_EXTRA, $urandom_range(0, 255));
    tx_idle_on = 1'b1;
    rx_stall_on = 1'b1;
    test_random_traffic(260, 35, 45);

    if (pending_outcomes.size() != 0)
      report_mismatch("results never delivered", 0, pending_outcomes.size());
    $display("%0d requests: %0d ok, %0d out of memory, %0d class not set, %0d too large",
             requests_sent, status_seen[ST_OK], status_seen[ST_NO_MEM],
             status_seen[ST_NOT_SET], status_seen[ST_TOO_BIG]);
    $display("%0d results checked, heap used up to byte %0d, %0d mismatches",
             results_checked, heap_top_bytes, error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
